[rtl/gpe_pkg.sv]
// ----------------------------------------------------------------------------
// gpe_pkg
// shared constants and controller/datapath interface types for the
// goldbach pair enumerator
// ----------------------------------------------------------------------------
`default_nettype none

package gpe_pkg;

  localparam int MAX_N      = 1024;
  localparam int N_W        = 11;
  localparam int P_W        = 10;
  localparam int FLAG_DEPTH = MAX_N + 1;
  localparam int TAB_DEPTH  = 172;
  localparam int TAB_AW     = 8;
  localparam int RESULT_CAP = 64;
  localparam int CNT_W      = 7;
  localparam int DIV_STEPS  = N_W;
  localparam int DIV_CW     = 4;
  localparam int SQ_W       = 2 * P_W;

  localparam logic [N_W-1:0] LIMIT_RESET = N_W'(MAX_N);
  localparam logic [N_W-1:0] MIN_TARGET  = N_W'(4);
  localparam logic [N_W-1:0] TWO         = N_W'(2);
  localparam logic [N_W-1:0] THREE       = N_W'(3);

  localparam logic REG_UPPER_LIMIT = 1'b0;

  typedef struct packed {
    logic cand_inc;
    logic k_clr;
    logic k_inc;
    logic tab_rd;
    logic tab_append;
    logic flag_wr;
    logic flag_val;
    logic div_start;
    logic in_load;
    logic flag_rd;
    logic pair_take;
    logic final_push;
  } gpe_cmd_t;

  typedef struct packed {
    logic cand_two;
    logic cand_odd_ge3;
    logic cand_last;
    logic k_end;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
    logic bad;
    logic p_over;
    logic flag_hit;
    logic pend_v;
    logic cap_next;
    logic out_free;
  } gpe_sts_t;

endpackage

`default_nettype wire

[rtl/gpe_ctrl.sv]
// ----------------------------------------------------------------------------
// gpe_ctrl
// sequencer for the prime build after reset and the per-query prime walk
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_ctrl
  import gpe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire gpe_sts_t sts,
  output gpe_cmd_t      cmd
);

  localparam logic [3:0] S_B_CAND = 4'd0;
  localparam logic [3:0] S_B_RD   = 4'd1;
  localparam logic [3:0] S_B_SQ   = 4'd2;
  localparam logic [3:0] S_B_DIV  = 4'd3;
  localparam logic [3:0] S_B_WR   = 4'd4;
  localparam logic [3:0] S_IDLE   = 4'd5;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_W_RD   = 4'd7;
  localparam logic [3:0] S_W_P    = 4'd8;
  localparam logic [3:0] S_W_F    = 4'd9;
  localparam logic [3:0] S_FINAL  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       prime_r, prime_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_B_CAND;
      prime_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prime_r <= prime_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    prime_nxt = prime_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_B_CAND: begin
        if (sts.cand_odd_ge3) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_B_RD;
        end else begin
          prime_nxt = sts.cand_two;
          state_nxt = S_B_WR;
        end
      end
      S_B_RD: begin
        if (sts.k_end) begin
          prime_nxt = 1'b1;
          state_nxt = S_B_WR;
        end else begin
          cmd.tab_rd = 1'b1;
          state_nxt  = S_B_SQ;
        end
      end
      S_B_SQ: begin
        if (sts.sq_gt) begin
          prime_nxt = 1'b1;
          state_nxt = S_B_WR;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_B_DIV;
        end
      end
      S_B_DIV: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            prime_nxt = 1'b0;
            state_nxt = S_B_WR;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_B_RD;
          end
        end
      end
      S_B_WR: begin
        cmd.flag_wr    = 1'b1;
        cmd.flag_val   = prime_r;
        cmd.tab_append = prime_r;
        cmd.cand_inc   = 1'b1;
        state_nxt      = sts.cand_last ? S_IDLE : S_B_CAND;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.bad ? S_FINAL : S_W_RD;
      end
      S_W_RD: begin
        if (sts.k_end) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.tab_rd = 1'b1;
          state_nxt  = S_W_P;
        end
      end
      S_W_P: begin
        if (sts.p_over) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.flag_rd = 1'b1;
          state_nxt   = S_W_F;
        end
      end
      S_W_F: begin
        if (!sts.flag_hit) begin
          cmd.k_inc = 1'b1;
          state_nxt = S_W_RD;
        end else if (!sts.pend_v || sts.out_free) begin
          cmd.pair_take = 1'b1;
          if (sts.cap_next) begin
            state_nxt = S_FINAL;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_W_RD;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.final_push = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/gpe_dp.sv]
// ----------------------------------------------------------------------------
// gpe_dp
// prime flag and prime list memories, remainder unit, walk registers and
// result register
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_dp
  import gpe_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire gpe_cmd_t       cmd,
  output gpe_sts_t            sts,
  input  wire logic [N_W-1:0] upper_limit,
  input  wire logic [N_W-1:0] in_even_target,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [N_W-1:0]      out_small_prime,
  output logic [N_W-1:0]      out_large_prime,
  output logic [N_W-1:0]      out_pair_sum,
  output logic                out_last_pair,
  output logic                out_bad_query
);

  logic             flag_mem [FLAG_DEPTH];
  logic [P_W-1:0]   tab_mem  [TAB_DEPTH];

  logic [N_W-1:0]    cand_r;
  logic [TAB_AW-1:0] k_r;
  logic [TAB_AW-1:0] total_r;
  logic [P_W-1:0]    tab_q_r;
  logic              flag_q_r;
  logic              hit_ok_r;

  logic [P_W-1:0]    rem_r;
  logic [N_W-1:0]    dvd_r;
  logic [DIV_CW-1:0] div_cnt_r;

  logic [N_W-1:0]    n_r;
  logic [N_W-1:0]    q_r;
  logic              pend_v_r;
  logic [N_W-1:0]    pend_p_r;
  logic [N_W-1:0]    pend_q_r;
  logic [CNT_W-1:0]  count_r;

  logic              out_valid_r;
  logic [N_W-1:0]    out_p_r;
  logic [N_W-1:0]    out_q_r;
  logic [N_W-1:0]    out_n_r;
  logic              out_last_r;
  logic              out_bad_r;

  logic [SQ_W-1:0]   sq;
  logic [N_W-1:0]    p_ext;
  logic [N_W-1:0]    q_calc;
  logic [N_W-1:0]    shifted;
  logic              out_free;

  assign sq       = SQ_W'(tab_q_r) * SQ_W'(tab_q_r);
  assign p_ext    = {1'b0, tab_q_r};
  assign q_calc   = n_r - p_ext;
  assign shifted  = {rem_r, dvd_r[N_W-1]};
  assign out_free = !out_valid_r || out_ready;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.flag_wr) begin
      flag_mem[cand_r] <= cmd.flag_val;
    end
    if (cmd.flag_rd) begin
      flag_q_r <= flag_mem[q_calc];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tab_append) begin
      tab_mem[total_r] <= cand_r[P_W-1:0];
    end
    if (cmd.tab_rd) begin
      tab_q_r <= tab_mem[k_r];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r      <= '0;
      k_r         <= '0;
      total_r     <= '0;
      div_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      hit_ok_r    <= 1'b0;
    end else begin
      if (cmd.cand_inc) begin
        cand_r <= cand_r + N_W'(1);
      end
      if (cmd.k_clr || cmd.in_load) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + TAB_AW'(1);
      end
      if (cmd.tab_append) begin
        total_r <= total_r + TAB_AW'(1);
      end
      if (cmd.div_start) begin
        div_cnt_r <= DIV_CW'(DIV_STEPS);
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - DIV_CW'(1);
      end
      if (cmd.flag_rd) begin
        hit_ok_r <= (q_calc <= N_W'(MAX_N));
      end
      if (cmd.in_load) begin
        pend_v_r <= 1'b0;
        count_r  <= '0;
      end else if (cmd.pair_take) begin
        pend_v_r <= 1'b1;
        count_r  <= count_r + CNT_W'(1);
      end
      if (cmd.final_push || (cmd.pair_take && pend_v_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      dvd_r <= cand_r;
    end else if (div_cnt_r != '0) begin
      dvd_r <= {dvd_r[N_W-2:0], 1'b0};
      if (shifted >= p_ext) begin
        rem_r <= P_W'(shifted - p_ext);
      end else begin
        rem_r <= shifted[P_W-1:0];
      end
    end
    if (cmd.in_load) begin
      n_r <= in_even_target;
    end
    if (cmd.flag_rd) begin
      q_r <= q_calc;
    end
    if (cmd.pair_take) begin
      pend_p_r <= p_ext;
      pend_q_r <= q_r;
    end
    if (cmd.final_push) begin
      out_p_r    <= pend_v_r ? pend_p_r : '0;
      out_q_r    <= pend_v_r ? pend_q_r : '0;
      out_n_r    <= n_r;
      out_last_r <= 1'b1;
      out_bad_r  <= sts.bad;
    end else if (cmd.pair_take && pend_v_r) begin
      out_p_r    <= pend_p_r;
      out_q_r    <= pend_q_r;
      out_n_r    <= n_r;
      out_last_r <= 1'b0;
      out_bad_r  <= 1'b0;
    end
  end

  always_comb begin
    sts.cand_two     = (cand_r == TWO);
    sts.cand_odd_ge3 = cand_r[0] && (cand_r >= THREE);
    sts.cand_last    = (cand_r == N_W'(MAX_N));
    sts.k_end        = (k_r == total_r);
    sts.sq_gt        = (sq > SQ_W'(cand_r));
    sts.div_done     = (div_cnt_r == '0);
    sts.rem_zero     = (rem_r == '0);
    sts.bad          = n_r[0] || (n_r < MIN_TARGET) || (n_r > upper_limit)
                       || (n_r > N_W'(MAX_N));
    sts.p_over       = (p_ext > (n_r >> 1));
    sts.flag_hit     = flag_q_r && hit_ok_r;
    sts.pend_v       = pend_v_r;
    sts.cap_next     = (count_r == CNT_W'(RESULT_CAP - 1));
    sts.out_free     = out_free;
  end

  assign out_valid       = out_valid_r;
  assign out_small_prime = out_p_r;
  assign out_large_prime = out_q_r;
  assign out_pair_sum    = out_n_r;
  assign out_last_pair   = out_last_r;
  assign out_bad_query   = out_bad_r;

endmodule

`default_nettype wire

[rtl/goldbach_pair_enumerator.sv]
// ----------------------------------------------------------------------------
// goldbach_pair_enumerator
// builds a prime map after reset, then lists up to RESULT_CAP prime pairs of
// each queried even number in rising order of the smaller prime
//
//   channel  ports                          transaction
//   in       in_valid / in_ready            one even target
//   out      out_valid / out_ready          one pair, or one refusal
//   cfg      psel penable pwrite paddr ...  upper_limit at word 0
//
// after reset the build visits every number up to MAX_N, trial dividing
// odd candidates through a one-bit-per-cycle remainder unit; in_ready
// stays low until it ends
// a query walks the listed primes up to half the target, with a list read
// and a flag read in each step; a refused query skips the walk; a full
// result register stalls the walk
// ----------------------------------------------------------------------------
`default_nettype none

module goldbach_pair_enumerator
  import gpe_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [N_W-1:0] in_even_target,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [N_W-1:0]      out_small_prime,
  output logic [N_W-1:0]      out_large_prime,
  output logic [N_W-1:0]      out_pair_sum,
  output logic                out_last_pair,
  output logic                out_bad_query,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [N_W-1:0] upper_limit_r;
  gpe_cmd_t       cmd;
  gpe_sts_t       sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_UPPER_LIMIT)) begin
      upper_limit_r <= pwdata[N_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_UPPER_LIMIT) ? {(32 - N_W)'(0), upper_limit_r} : '0;

  gpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpe_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .upper_limit     (upper_limit_r),
    .in_even_target  (in_even_target),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_small_prime (out_small_prime),
    .out_large_prime (out_large_prime),
    .out_pair_sum    (out_pair_sum),
    .out_last_pair   (out_last_pair),
    .out_bad_query   (out_bad_query)
  );

endmodule

`default_nettype wire

[dv/goldbach_pair_enumerator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// goldbach_pair_enumerator_tb
// self-checking bench for the goldbach pair enumerator: waits out the prime
// build after reset, sends even targets (and refused ones) under random
// valid/ready idling and two long result stalls, predicts every pair from its
// own trial-division prime map and checks each result transaction in order,
// across the reset upper_limit and further settings written through the apb port
// ----------------------------------------------------------------------------
module goldbach_pair_enumerator_tb;
  import gpe_pkg::*;

  localparam int          CLK_HALF        = 2;
  localparam int          RESET_CYCLES    = 8;
  localparam int          IDLE_PCT        = 34;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          SETTLE_CYCLES   = 400;
  localparam int          WATCHDOG_LIMIT  = 400000;
  localparam int          REPORT_LIMIT    = 10;
  localparam logic [2:0]  LIMIT_ADDR      = 3'(4 * int'(REG_UPPER_LIMIT));
  localparam logic [2:0]  SPARE_ADDR      = 3'(4 * (int'(REG_UPPER_LIMIT) + 1));

  typedef struct packed {
    logic [N_W-1:0] lo_prime;
    logic [N_W-1:0] hi_prime;
    logic [N_W-1:0] target;
    logic           last;
    logic           bad;
  } pair_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [N_W-1:0] in_even_target = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [N_W-1:0] out_small_prime;
  logic [N_W-1:0] out_large_prime;
  logic [N_W-1:0] out_pair_sum;
  logic           out_last_pair;
  logic           out_bad_query;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  logic [N_W-1:0] target_queue[$];
  pair_t          pair_queue[$];
  bit             prime_flag[0:MAX_N];
  int             prime_list[$];
  logic [N_W-1:0] limit_now = LIMIT_RESET;

  int targets_sent = 0;
  int refused_seen = 0;
  int pairs_seen   = 0;
  int mismatches   = 0;
  int hold_left    = 0;
  int holds_done   = 0;
  int quiet_cycles = 0;
  logic [N_W-1:0] mid_limit;

  wire calm = (targets_sent >= 200) && (targets_sent < 260);

  goldbach_pair_enumerator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_even_target  (in_even_target),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_small_prime (out_small_prime),
    .out_large_prime (out_large_prime),
    .out_pair_sum    (out_pair_sum),
    .out_last_pair   (out_last_pair),
    .out_bad_query   (out_bad_query),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // trial division by the listed primes up to the square root
  function automatic void list_primes();
    int  c;
    bit  is_p;
    prime_list.delete();
    for (int i = 0; i <= MAX_N; i++) prime_flag[i] = 1'b0;
    prime_list.push_back(2);
    prime_flag[2] = 1'b1;
    for (c = 3; c <= MAX_N; c += 2) begin
      is_p = 1'b1;
      foreach (prime_list[k]) begin
        if (prime_list[k] * prime_list[k] > c) break;
        if (c % prime_list[k] == 0) begin
          is_p = 1'b0;
          break;
        end
      end
      if (is_p && prime_list.size() < TAB_DEPTH) begin
        prime_list.push_back(c);
        prime_flag[c] = 1'b1;
      end
    end
  endfunction

  function automatic void enumerate_pairs(input logic [N_W-1:0] n);
    int    half;
    int    cnt;
    int    p;
    pair_t r;
    if (n[0] || n < MIN_TARGET || n > limit_now || int'(n) > MAX_N) begin
      pair_queue.push_back(pair_t'{'0, '0, n, 1'b1, 1'b1});
      refused_seen++;
      return;
    end
    cnt  = 0;
    half = int'(n) / 2;
    foreach (prime_list[k]) begin
      p = prime_list[k];
      if (p > half) break;
      if (prime_flag[int'(n) - p]) begin
        pair_queue.push_back(pair_t'{N_W'(p), N_W'(int'(n) - p), n, 1'b0, 1'b0});
        cnt++;
        if (cnt >= RESULT_CAP) break;
      end
    end
    if (cnt == 0) begin
      pair_queue.push_back(pair_t'{'0, '0, n, 1'b1, 1'b0});
    end else begin
      r = pair_queue.pop_back();
      r.last = 1'b1;
      pair_queue.push_back(r);
    end
  endfunction

  function automatic logic [N_W-1:0] pick_target(input logic [N_W-1:0] lim);
    int r;
    r = $urandom_range(99);
    if (r < 70 && lim >= MIN_TARGET) return N_W'(2 * $urandom_range(2, int'(lim) / 2));
    if (r < 80) return N_W'(2 * $urandom_range(0, 511) + 1);
    if (r < 87) return N_W'($urandom_range(0, 3));
    if (r < 95 && int'(lim) < MAX_N) return N_W'($urandom_range(int'(lim) + 1, MAX_N));
    if (r < 97) return N_W'(MAX_N);
    return N_W'($urandom_range(0, MAX_N));
  endfunction

  // input driver
  always @(posedge clk) begin : drive_targets
    logic take;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take) begin
        enumerate_pairs(in_even_target);
        targets_sent++;
      end
      if (!in_valid || take) begin
        if (target_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid       <= 1'b1;
          in_even_target <= target_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin : check_pairs
    pair_t got;
    pair_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_small_prime, out_large_prime, out_pair_sum, out_last_pair,
                out_bad_query};
        pairs_seen++;
        if (pair_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected transaction: p=%0d q=%0d sum=%0d last=%0b bad=%0b",
                     got.lo_prime, got.hi_prime, got.target, got.last, got.bad);
        end else begin
          want = pair_queue.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"mismatch: exp p=%0d q=%0d sum=%0d last=%0b bad=%0b,",
                        " got p=%0d q=%0d sum=%0d last=%0b bad=%0b"},
                       want.lo_prime, want.hi_prime, want.target, want.last, want.bad,
                       got.lo_prime, got.hi_prime, got.target, got.last, got.bad);
          end
        end
      end
      // long stalls of the receiver while targets keep coming
      if (hold_left == 0 && ((holds_done == 0 && targets_sent >= 150) ||
                             (holds_done == 1 && targets_sent >= 300))) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 quiet_cycles, pair_queue.size());
        $display("goldbach_pair_enumerator test failed");
        $finish;
      end
    end
  end

  task automatic cfg_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_limit();
    logic [31:0] rd;
    cfg_access(1'b0, LIMIT_ADDR, '0, rd);
    if (rd[N_W-1:0] !== limit_now) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("upper_limit readback: exp %0d got %0d", limit_now, rd[N_W-1:0]);
    end
  endtask

  task automatic write_limit(input logic [N_W-1:0] value);
    logic [31:0] rd;
    cfg_access(1'b1, LIMIT_ADDR, 32'(value), rd);
    limit_now = value;
    check_limit();
  endtask

  task automatic drain();
    while (target_queue.size() != 0 || in_valid || pair_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] rd;
    list_primes();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset limit, extremes and refusals
    target_queue = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd6, 11'd7, 11'd8,
                     11'd12, 11'd128, 11'd256, 11'd512, 11'd998, 11'd1000, 11'd1022,
                     11'd1023, 11'd1024, 11'd2, 11'd4};
    drain();
    check_limit();

    // smallest limit; a write to an unmapped word must not change it
    write_limit(MIN_TARGET);
    cfg_access(1'b1, SPARE_ADDR, 32'h0000_07fe, rd);
    check_limit();
    target_queue = '{11'd4, 11'd6, 11'd2, 11'd3, 11'd1024, 11'd0, 11'd5, 11'd8};
    drain();

    // random mid-range limit
    mid_limit = N_W'($urandom_range(5, MAX_N - 1));
    write_limit(mid_limit);
    target_queue.push_back(mid_limit);
    target_queue.push_back(mid_limit + N_W'(1));
    target_queue.push_back(mid_limit & ~N_W'(1));
    target_queue.push_back(N_W'(MAX_N));
    for (int i = 0; i < 96; i++) target_queue.push_back(pick_target(mid_limit));
    drain();

    // largest limit with the long stalls and the calm stretch
    write_limit(N_W'(MAX_N));
    for (int i = 0; i < 232; i++) target_queue.push_back(pick_target(N_W'(MAX_N)));
    drain();

    $display("sent %0d targets (%0d refused), checked %0d result transactions",
             targets_sent, refused_seen, pairs_seen);
    $display("upper_limit settings: %0d, %0d, %0d, %0d; %0d receiver stalls of %0d cycles",
             MAX_N, MIN_TARGET, mid_limit, MAX_N, holds_done, HOLD_CYCLES);
    if (mismatches == 0 && pair_queue.size() == 0) begin
      $display("goldbach_pair_enumerator test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pair_queue.size());
      $display("goldbach_pair_enumerator test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gpe_pkg.sv
rtl/gpe_ctrl.sv
rtl/gpe_dp.sv
rtl/goldbach_pair_enumerator.sv
dv/goldbach_pair_enumerator_tb.sv
